// ----- hdl/sagl_pkg.sv -----
`timescale 1ns / 1ps
package sagl_pkg;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int COEF_BITS_DEF = 24;
    localparam int GAIN_BITS = 19;
    localparam int CFG_IDX_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    localparam logic [2:0] REG_LEVEL_ATTACK = 3'd0;
    localparam logic [2:0] REG_LEVEL_RELEASE = 3'd1;
    localparam logic [2:0] REG_GAIN_DOWN = 3'd2;
    localparam logic [2:0] REG_GAIN_UP = 3'd3;
    localparam logic [2:0] REG_STRENGTH = 3'd4;
    localparam logic [2:0] REG_OUT_LEVEL = 3'd5;
    localparam logic [2:0] REG_THRESHOLD = 3'd6;
    localparam logic [2:0] REG_CEILING = 3'd7;

    localparam logic [18:0] UNITY = 19'd65536;
    localparam logic [14:0] PEAK_FACTOR = 15'd22938;
    localparam logic [13:0] TARGET_LEVEL = 14'd11796;
    localparam logic [18:0] MIN_LEVEL = 19'd786;
    localparam logic [18:0] MIN_GAIN = 19'd13107;
    localparam logic [18:0] MAX_GAIN = 19'd294912;
    localparam logic [16:0] MIN_OUT_LEVEL = 17'd6554;

    // Datapath operations, each issued by one controller state.
    localparam logic [3:0] OP_NONE = 4'd0;
    localparam logic [3:0] OP_LOAD = 4'd1;
    localparam logic [3:0] OP_SQ = 4'd2;
    localparam logic [3:0] OP_SQRT = 4'd3;
    localparam logic [3:0] OP_ENV = 4'd4;
    localparam logic [3:0] OP_DIV = 4'd5;
    localparam logic [3:0] OP_BLEND = 4'd6;
    localparam logic [3:0] OP_GAIN = 4'd7;
    localparam logic [3:0] OP_SCALE1 = 4'd8;
    localparam logic [3:0] OP_SCALE2 = 4'd9;
    localparam logic [3:0] OP_SHAPE = 4'd10;

    typedef struct packed {
        logic [3:0] op;
        logic       first;
    } sagl_cmd_t;

    typedef struct packed {
        logic step_done;
    } sagl_stat_t;
endpackage

// ----- hdl/sagl_ctrl.sv -----
`timescale 1ns / 1ps
module sagl_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_fire,
    input  logic                 out_busy,
    output logic                 in_ready,
    output logic                 out_load,
    output sagl_pkg::sagl_cmd_t  cmd,
    input  sagl_pkg::sagl_stat_t stat
);
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_SQ = 4'd1;
    localparam logic [3:0] ST_SQRT = 4'd2;
    localparam logic [3:0] ST_ENV = 4'd3;
    localparam logic [3:0] ST_DIV = 4'd4;
    localparam logic [3:0] ST_BLEND = 4'd5;
    localparam logic [3:0] ST_GAIN = 4'd6;
    localparam logic [3:0] ST_SC1 = 4'd7;
    localparam logic [3:0] ST_SC2 = 4'd8;
    localparam logic [3:0] ST_SHAPE = 4'd9;
    localparam logic [3:0] ST_OUT = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       first_reg, first_next;

    always_comb begin
        state_next = state_reg;
        first_next = 1'b0;
        cmd.op = sagl_pkg::OP_NONE;
        cmd.first = first_reg;
        in_ready = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.op = sagl_pkg::OP_LOAD;
                    state_next = ST_SQ;
                end
            end
            ST_SQ: begin
                cmd.op = sagl_pkg::OP_SQ;
                state_next = ST_SQRT;
                first_next = 1'b1;
            end
            ST_SQRT: begin
                cmd.op = sagl_pkg::OP_SQRT;
                if (stat.step_done) state_next = ST_ENV;
            end
            ST_ENV: begin
                cmd.op = sagl_pkg::OP_ENV;
                state_next = ST_DIV;
                first_next = 1'b1;
            end
            ST_DIV: begin
                cmd.op = sagl_pkg::OP_DIV;
                if (stat.step_done) state_next = ST_BLEND;
            end
            ST_BLEND: begin
                cmd.op = sagl_pkg::OP_BLEND;
                state_next = ST_GAIN;
            end
            ST_GAIN: begin
                cmd.op = sagl_pkg::OP_GAIN;
                state_next = ST_SC1;
            end
            ST_SC1: begin
                cmd.op = sagl_pkg::OP_SCALE1;
                state_next = ST_SC2;
            end
            ST_SC2: begin
                cmd.op = sagl_pkg::OP_SCALE2;
                state_next = ST_SHAPE;
                first_next = 1'b1;
            end
            ST_SHAPE: begin
                cmd.op = sagl_pkg::OP_SHAPE;
                if (stat.step_done) state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!out_busy) begin
                    out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            first_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            first_reg <= first_next;
        end
    end

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        in_ready |-> state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_fire_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> state_reg == ST_SQ)
        else $error("accepted request did not start work");
    a_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> state_reg == ST_IDLE)
        else $error("result load did not return to idle");
endmodule

// ----- hdl/sagl_datapath.sv -----
`timescale 1ns / 1ps
module sagl_datapath #(
    parameter int SAMPLE_BITS = sagl_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS = sagl_pkg::COEF_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  sagl_pkg::sagl_cmd_t    cmd,
    output sagl_pkg::sagl_stat_t   stat,
    input  logic [SAMPLE_BITS-1:0] in_left,
    input  logic [SAMPLE_BITS-1:0] in_right,
    input  logic [COEF_BITS-1:0]   attack_coef,
    input  logic [COEF_BITS-1:0]   release_coef,
    input  logic [COEF_BITS-1:0]   down_coef,
    input  logic [COEF_BITS-1:0]   up_coef,
    input  logic [16:0]            strength,
    input  logic [16:0]            out_level,
    input  logic [23:0]            threshold,
    input  logic [23:0]            ceiling,
    output logic [SAMPLE_BITS-1:0] left_out,
    output logic [SAMPLE_BITS-1:0] right_out,
    output logic [18:0]            gain_out
);
    localparam int GB = sagl_pkg::GAIN_BITS;
    // Magnitudes are held in Q1.31 (up to 2^31, 32 bits).
    localparam int SH = 32 - SAMPLE_BITS;

    logic [31:0] lm_reg, rm_reg;
    logic        ln_reg, rn_reg;
    logic [63:0] lsq_reg, rsq_reg;
    logic [33:0] ms_reg;       // (L^2+R^2)>>31 fits 33 bits
    logic [33:0] rad_reg;
    logic [17:0] root_reg;
    logic [4:0]  cnt_reg;
    logic [18:0] peak_lvl_reg;
    logic [GB-1:0] env_reg, gain_reg;
    logic [30:0] rem_reg;      // division remainder
    logic [30:0] quo_reg;
    logic [18:0] target_reg;
    logic [18:0] blend_reg;
    logic [49:0] lsc_reg, rsc_reg;
    logic [32:0] lm2_reg, rm2_reg; // magnitudes after compression

    // Sign split, aligned to Q1.31.
    logic [SAMPLE_BITS-1:0] lmag, rmag;
    assign lmag = in_left[SAMPLE_BITS-1] ? (~in_left + 1'b1) : in_left;
    assign rmag = in_right[SAMPLE_BITS-1] ? (~in_right + 1'b1) : in_right;

    // Peak level
    logic [31:0] peak;
    logic [46:0] peak_prod;
    assign peak = (lm_reg > rm_reg) ? lm_reg : rm_reg;
    assign peak_prod = peak * sagl_pkg::PEAK_FACTOR;

    // Square root: two bits of radicand per cycle.
    logic [35:0] sq_trial;
    assign sq_trial = {root_reg, 2'b01};

    // Envelope follower
    logic [18:0] inst;
    logic [18:0] env_diff;
    logic        env_up;
    logic [COEF_BITS-1:0] env_coef;
    logic [GB+COEF_BITS-1:0] env_prod;
    assign inst = ({1'b0, root_reg} > peak_lvl_reg) ? {1'b0, root_reg} : peak_lvl_reg;
    assign env_up = inst > env_reg;
    assign env_diff = env_up ? (inst - env_reg) : (env_reg - inst);
    assign env_coef = env_up ? attack_coef : release_coef;
    assign env_prod = env_diff * env_coef;

    logic [18:0] env_div;
    assign env_div = (env_reg > sagl_pkg::MIN_LEVEL) ? env_reg : sagl_pkg::MIN_LEVEL;

    // Restoring division, one quotient bit per cycle.
    logic [31:0] div_try;
    assign div_try = {rem_reg, quo_reg[29]} - {13'd0, env_div};

    // Blend
    logic [16:0] s_eff;
    logic [18:0] tgt_clamped, tdiff;
    logic [35:0] blend_prod;
    logic        tgt_up;
    always_comb begin
        tgt_clamped = quo_reg[18:0];
        if (quo_reg < 31'(sagl_pkg::MIN_GAIN)) tgt_clamped = sagl_pkg::MIN_GAIN;
        if (quo_reg > 31'(sagl_pkg::MAX_GAIN)) tgt_clamped = sagl_pkg::MAX_GAIN;
    end
    assign s_eff = (strength > 17'd65536) ? 17'd65536 : strength;
    assign tgt_up = target_reg >= sagl_pkg::UNITY;
    assign tdiff = tgt_up ? (target_reg - sagl_pkg::UNITY) : (sagl_pkg::UNITY - target_reg);
    assign blend_prod = tdiff * s_eff;

    // Gain smoothing
    logic        g_up;
    logic [18:0] g_diff;
    logic [COEF_BITS-1:0] g_coef;
    logic [GB+COEF_BITS-1:0] g_prod;
    assign g_up = !(blend_reg < gain_reg);
    assign g_diff = g_up ? (blend_reg - gain_reg) : (gain_reg - blend_reg);
    assign g_coef = g_up ? up_coef : down_coef;
    assign g_prod = g_diff * g_coef;

    // Channel scaling
    logic [16:0] lvl;
    always_comb begin
        lvl = out_level;
        if (out_level < sagl_pkg::MIN_OUT_LEVEL) lvl = sagl_pkg::MIN_OUT_LEVEL;
        if (out_level > 17'd65536) lvl = 17'd65536;
    end

    // Compression by 6, done as a multiply by the reciprocal with correction.
    logic [33:0] thr, ceil_v;
    assign thr = {2'b0, threshold, 8'd0};
    assign ceil_v = {2'b0, ceiling, 8'd0};

    function automatic logic [33:0] div6(input logic [33:0] x);
        logic [68:0] p;
        logic [33:0] q;
        logic [36:0] r;
        p = x * 35'h2AAAAAAAB;
        q = {1'b0, p[68:36]};
        r = {3'd0, x} - ({3'd0, q} * 37'd6);
        if (r >= 37'd6) q = q + 34'd1;
        return q;
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] finish(input logic [33:0] m, input logic neg,
                                                      input logic [33:0] cl);
        logic [33:0] c, t;
        logic [33:0] lim;
        c = m;
        if (c > cl) c = cl;
        t = c >> SH;
        lim = 34'd1 << (SAMPLE_BITS - 1);
        if (!neg) begin
            if (t > lim - 34'd1) t = lim - 34'd1;
            return t[SAMPLE_BITS-1:0];
        end
        if (t > lim) t = lim;
        return SAMPLE_BITS'((34'd1 << SAMPLE_BITS) - t);
    endfunction

    // Scaled magnitude: lsc holds m*gain>>16 (<=2^33.2), then *level>>16.
    logic [33:0] l_m, r_m;
    assign l_m = lsc_reg[33:0];
    assign r_m = rsc_reg[33:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            env_reg <= '0;
            gain_reg <= sagl_pkg::UNITY;
            cnt_reg <= '0;
        end else begin
            case (cmd.op)
                sagl_pkg::OP_LOAD: begin
                    lm_reg <= 32'(lmag) << SH;
                    rm_reg <= 32'(rmag) << SH;
                    ln_reg <= in_left[SAMPLE_BITS-1];
                    rn_reg <= in_right[SAMPLE_BITS-1];
                end
                sagl_pkg::OP_SQ: begin
                    lsq_reg <= lm_reg * lm_reg;
                    rsq_reg <= rm_reg * rm_reg;
                    peak_lvl_reg <= 19'(peak_prod >> 31);
                end
                sagl_pkg::OP_SQRT: begin
                    if (cmd.first) begin
                        ms_reg <= 34'((lsq_reg + rsq_reg) >> 31);
                        rad_reg <= '0;
                        root_reg <= '0;
                        cnt_reg <= 5'd17;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                        ms_reg <= {ms_reg[31:0], 2'b00};
                        if ({rad_reg[31:0], ms_reg[33:32]} >= sq_trial[33:0]) begin
                            rad_reg <= {rad_reg[31:0], ms_reg[33:32]} - sq_trial[33:0];
                            root_reg <= {root_reg[16:0], 1'b1};
                        end else begin
                            rad_reg <= {rad_reg[31:0], ms_reg[33:32]};
                            root_reg <= {root_reg[16:0], 1'b0};
                        end
                    end
                end
                sagl_pkg::OP_ENV: begin
                    if (env_up)
                        env_reg <= env_reg + GB'(env_prod >> COEF_BITS);
                    else
                        env_reg <= env_reg - GB'(env_prod >> COEF_BITS);
                end
                sagl_pkg::OP_DIV: begin
                    if (cmd.first) begin
                        rem_reg <= '0;
                        quo_reg <= {1'b0, sagl_pkg::TARGET_LEVEL, 16'd0};
                        cnt_reg <= 5'd30;
                    end else begin
                        cnt_reg <= cnt_reg - 5'd1;
                        if (!div_try[31]) begin
                            rem_reg <= div_try[30:0];
                            quo_reg <= {quo_reg[29:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[29:0], quo_reg[29]};
                            quo_reg <= {quo_reg[29:0], 1'b0};
                        end
                    end
                end
                sagl_pkg::OP_BLEND: target_reg <= tgt_clamped;
                sagl_pkg::OP_GAIN: begin
                    blend_reg <= tgt_up ? (sagl_pkg::UNITY + 19'(blend_prod >> 16))
                                        : (sagl_pkg::UNITY - 19'(blend_prod >> 16));
                end
                sagl_pkg::OP_SCALE1: begin
                    if (g_up) gain_reg <= gain_reg + GB'(g_prod >> COEF_BITS);
                    else gain_reg <= gain_reg - GB'(g_prod >> COEF_BITS);
                end
                sagl_pkg::OP_SCALE2: begin
                    lsc_reg <= 50'(lm_reg * gain_reg) >> 16;
                    rsc_reg <= 50'(rm_reg * gain_reg) >> 16;
                end
                sagl_pkg::OP_SHAPE: begin
                    if (cmd.first) begin
                        lsc_reg <= 50'(l_m * lvl) >> 16;
                        rsc_reg <= 50'(r_m * lvl) >> 16;
                        cnt_reg <= 5'd1;
                    end else begin
                        cnt_reg <= '0;
                        lm2_reg <= 33'((l_m > thr) ? thr + div6(l_m - thr) : l_m);
                        rm2_reg <= 33'((r_m > thr) ? thr + div6(r_m - thr) : r_m);
                    end
                end
                default: ;
            endcase
        end
    end

    // The counter is loaded with the step count; the last step runs at count one.
    assign stat.step_done = !cmd.first && cnt_reg == 5'd1;
    assign left_out = finish({1'b0, lm2_reg}, ln_reg, ceil_v);
    assign right_out = finish({1'b0, rm2_reg}, rn_reg, ceil_v);
    assign gain_out = gain_reg;

    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        gain_reg <= sagl_pkg::MAX_GAIN)
        else $error("gain out of range");
    a_env_range: assert property (@(posedge aclk) disable iff (!aresetn)
        env_reg <= 19'd262144)
        else $error("envelope out of range");
    a_target_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == sagl_pkg::OP_GAIN |-> target_reg >= sagl_pkg::MIN_GAIN &&
        target_reg <= sagl_pkg::MAX_GAIN)
        else $error("target out of range");
endmodule

// ----- hdl/stereo_auto_gain_leveler.sv -----
`timescale 1ns / 1ps
// Stereo leveler: one frame at a time. The result is loaded into the output
// register once the frame has passed a 17-step square root and a 30-step
// divider, each with a setup step, plus one step each for the squares, envelope,
// blend, gain and scaling and two for shaping. The next frame is accepted in the
// cycle after the result has been loaded into the output register, which may
// still be waiting to be taken, so no new frame is accepted while one is in work;
// an untaken previous result holds off the load.
module stereo_auto_gain_leveler #(
    parameter int SAMPLE_BITS = sagl_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS = sagl_pkg::COEF_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_left_sample,
    input  logic [SAMPLE_BITS-1:0] s_right_sample,
    input  logic                   s_frame_last,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [SAMPLE_BITS-1:0] m_left_result,
    output logic [SAMPLE_BITS-1:0] m_right_result,
    output logic [18:0]            m_applied_gain,
    output logic                   m_result_last,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [2:0]             cfg_index,
    input  logic [31:0]            cfg_data
);
    sagl_pkg::sagl_cmd_t  cmd;
    sagl_pkg::sagl_stat_t stat;
    logic in_fire, out_load;
    logic [COEF_BITS-1:0] att_reg, rel_reg, dn_reg, up_reg;
    logic [16:0] str_reg, lvl_reg;
    logic [23:0] thr_reg, ceil_reg;
    logic last_reg, valid_reg;
    logic [SAMPLE_BITS-1:0] lres_reg, rres_reg;
    logic [18:0] gres_reg;
    logic [SAMPLE_BITS-1:0] l_dp, r_dp;
    logic [18:0] g_dp;

    assign cfg_ready = 1'b1;
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            att_reg <= '1; rel_reg <= '1; dn_reg <= '1; up_reg <= '1;
            str_reg <= 17'd65536; lvl_reg <= 17'd65536;
            thr_reg <= 24'd8388608; ceil_reg <= 24'd8388608;
        end else if (cfg_valid) begin
            case (cfg_index)
                sagl_pkg::REG_LEVEL_ATTACK: att_reg <= cfg_data[COEF_BITS-1:0];
                sagl_pkg::REG_LEVEL_RELEASE: rel_reg <= cfg_data[COEF_BITS-1:0];
                sagl_pkg::REG_GAIN_DOWN: dn_reg <= cfg_data[COEF_BITS-1:0];
                sagl_pkg::REG_GAIN_UP: up_reg <= cfg_data[COEF_BITS-1:0];
                sagl_pkg::REG_STRENGTH: str_reg <= cfg_data[16:0];
                sagl_pkg::REG_OUT_LEVEL: lvl_reg <= cfg_data[16:0];
                sagl_pkg::REG_THRESHOLD: thr_reg <= cfg_data[23:0];
                sagl_pkg::REG_CEILING: ceil_reg <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) last_reg <= s_frame_last;
    end

    sagl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .in_fire(in_fire),
        .out_busy(valid_reg && !m_ready), .in_ready(s_ready),
        .out_load(out_load), .cmd(cmd), .stat(stat)
    );

    sagl_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .COEF_BITS(COEF_BITS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .in_left(s_left_sample), .in_right(s_right_sample),
        .attack_coef(att_reg), .release_coef(rel_reg),
        .down_coef(dn_reg), .up_coef(up_reg),
        .strength(str_reg), .out_level(lvl_reg),
        .threshold(thr_reg), .ceiling(ceil_reg),
        .left_out(l_dp), .right_out(r_dp), .gain_out(g_dp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (out_load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            lres_reg <= l_dp;
            rres_reg <= r_dp;
            gres_reg <= g_dp;
            m_result_last <= last_reg;
        end
    end

    assign m_valid = valid_reg;
    assign m_left_result = lres_reg;
    assign m_right_result = rres_reg;
    assign m_applied_gain = gres_reg;
endmodule
